[hw/rtl/asw_pkg.sv]
// Shared types and constants for the ARQ sender window.
// Used by asw_cell, asw_row, arq_sender_window and asw_checker.
// No dependencies.
package asw_pkg;

   localparam int WINDOW       = 8;
   localparam int CNT_W        = $clog2(WINDOW + 1);
   localparam int PACKET_W     = 16;
   localparam int TIME_W       = 32;
   localparam int WIU_W        = 4;
   localparam int FILL_W       = 4;
   localparam int RETX_W       = 16;
   localparam int MODE_W       = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = PACKET_W + TIME_W;
   localparam int RSP_FIELDS_W = 5 + PACKET_W + RETX_W + FILL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic              GBN_RESET     = 1'b0;
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(1000000);
   localparam logic [WIU_W-1:0]  WIU_RESET     = WIU_W'(8);
   localparam logic [FILL_W-1:0] FILL_MAX      = {FILL_W{1'b1}};
   localparam logic [RETX_W-1:0] RETX_MAX      = {RETX_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ_PACKET,
      MODE_ENQ_END,
      MODE_ACK,
      MODE_POLL
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GO_BACK_N,
      CSR_TIMEOUT_US,
      CSR_WINDOW_IN_USE
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_ENQ,
      OP_MATCH,
      OP_SHIFT,
      OP_EVAL,
      OP_SELECT,
      OP_UPDATE
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ,
      ST_MATCH,
      ST_SHIFT,
      ST_EVAL,
      ST_SELECT,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic occ;
      logic last;
      logic sent;
      logic acked;
      logic resend;
   } flags_type;

   typedef struct packed {
      flags_type             flags;
      logic [PACKET_W-1:0]   packet;
      logic [TIME_W-1:0]     stamp;
   } slot_type;

   typedef struct packed {
      cell_op_type           op;
      logic                  end_marker;
      logic [PACKET_W-1:0]   packet;
      logic [TIME_W-1:0]     now;
      logic [TIME_W-1:0]     timeout;
      logic                  rewind;
   } cell_cmd_type;

   typedef struct packed {
      logic                  found;
      logic                  run;
      logic                  taken;
      logic                  prefix;
      logic                  hit;
      logic [CNT_W-1:0]      count;
      logic [PACKET_W-1:0]   sel_packet;
      logic                  sel_timed;
      logic                  sel_resend;
   } up_link_type;

   typedef struct packed {
      logic                  ok;
      slot_type              slot;
   } down_link_type;

   localparam up_link_type UP_LINK_START = '{
      found: 1'b0, run: 1'b1, taken: 1'b0, prefix: 1'b1, hit: 1'b0,
      count: '0, sel_packet: '0, sel_timed: 1'b0, sel_resend: 1'b0
   };

   localparam down_link_type DOWN_LINK_END = '0;

   typedef struct packed {
      logic [TIME_W-1:0]     now;
      logic [PACKET_W-1:0]   pkt_id;
   } req_data_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0]  pad;
      logic [FILL_W-1:0]     window_fill;
      logic [RETX_W-1:0]     retransmit_total;
      logic                  end_reached;
      logic                  timed_out;
      logic                  send_is_retransmit;
      logic [PACKET_W-1:0]   send_packet;
      logic                  send_valid;
      logic                  accepted;
   } rsp_data_type;

endpackage

[hw/rtl/asw_cell.sv]
// One window slot: descriptor flags, packet number and send time.
// Links to its lower and upper neighbors; depends on asw_pkg.
module asw_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  asw_pkg::cell_cmd_type  cmd,
   input  logic                   in_use,
   input  asw_pkg::up_link_type   up_in,
   output asw_pkg::up_link_type   up_out,
   input  asw_pkg::down_link_type down_in,
   output asw_pkg::down_link_type down_out
);

   asw_pkg::flags_type            flags_ff, flags_in;
   logic [asw_pkg::PACKET_W-1:0]  packet_ff, packet_in;
   logic [asw_pkg::TIME_W-1:0]    stamp_ff, stamp_in;
   logic                          timed_ff, timed_in;
   logic                          chosen_ff, chosen_in;

   logic                          live;
   logic                          found_here;
   logic                          free_here;
   logic                          run_out;
   logic                          hit_here;
   logic                          cand;
   logic                          pick;
   logic                          prefix_here;
   logic [asw_pkg::TIME_W-1:0]    elapsed;

   assign live        = in_use & flags_ff.occ & ~flags_ff.last;
   assign found_here  = in_use & ~flags_ff.occ;
   assign free_here   = found_here & ~up_in.found;
   assign run_out     = up_in.run & flags_ff.occ & in_use;
   assign hit_here    = live & (packet_ff == cmd.packet);
   assign cand        = live & (~flags_ff.sent | timed_ff);
   assign pick        = cand & ~up_in.taken;
   assign prefix_here = up_in.prefix & live;
   assign elapsed     = cmd.now - stamp_ff;

   always_comb begin
      up_out.found      = up_in.found | found_here;
      up_out.run        = run_out;
      up_out.taken      = up_in.taken | cand;
      up_out.prefix     = prefix_here;
      up_out.hit        = up_in.hit | hit_here;
      up_out.count      = up_in.count + asw_pkg::CNT_W'(in_use & flags_ff.occ);
      up_out.sel_packet = pick ? packet_ff : up_in.sel_packet;
      up_out.sel_timed  = pick ? timed_ff : up_in.sel_timed;
      up_out.sel_resend = pick ? flags_ff.resend : up_in.sel_resend;
   end

   always_comb begin
      down_out.ok           = run_out;
      down_out.slot.flags   = flags_ff;
      down_out.slot.packet  = packet_ff;
      down_out.slot.stamp   = stamp_ff;
   end

   always_comb begin
      flags_in  = flags_ff;
      packet_in = packet_ff;
      stamp_in  = stamp_ff;
      timed_in  = timed_ff;
      chosen_in = chosen_ff;
      case (cmd.op)
         asw_pkg::OP_ENQ: begin
            if (free_here) begin
               flags_in      = '0;
               flags_in.occ  = 1'b1;
               flags_in.last = cmd.end_marker;
               packet_in     = cmd.packet;
            end
         end
         asw_pkg::OP_MATCH: begin
            if (hit_here) begin
               flags_in.acked = 1'b1;
            end
         end
         asw_pkg::OP_SHIFT: begin
            if (in_use) begin
               if (down_in.ok) begin
                  flags_in  = down_in.slot.flags;
                  packet_in = down_in.slot.packet;
                  stamp_in  = down_in.slot.stamp;
               end else begin
                  flags_in = '0;
               end
            end
         end
         asw_pkg::OP_EVAL: begin
            timed_in = live & flags_ff.sent & ~flags_ff.acked & (elapsed > cmd.timeout);
         end
         asw_pkg::OP_SELECT: begin
            chosen_in = pick;
         end
         asw_pkg::OP_UPDATE: begin
            if (chosen_ff) begin
               flags_in.sent   = 1'b1;
               flags_in.resend = 1'b0;
               stamp_in        = cmd.now;
            end else if (cmd.rewind & prefix_here) begin
               flags_in.sent   = 1'b0;
               flags_in.acked  = 1'b0;
               flags_in.resend = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= '0;
         timed_ff  <= 1'b0;
         chosen_ff <= 1'b0;
      end else begin
         flags_ff  <= flags_in;
         timed_ff  <= timed_in;
         chosen_ff <= chosen_in;
      end
   end

   always_ff @(posedge clock) begin
      packet_ff <= packet_in;
      stamp_ff  <= stamp_in;
   end

endmodule

[hw/rtl/asw_row.sv]
// Row of window slot cells with the links between neighbors.
// Decodes the slots in use; depends on asw_pkg and asw_cell.
module asw_row (
   input  logic                        clock,
   input  logic                        reset,
   input  asw_pkg::cell_cmd_type       cmd,
   input  logic [asw_pkg::WIU_W-1:0]   window_in_use,
   output asw_pkg::flags_type          head,
   output asw_pkg::up_link_type        tail
);

   logic [asw_pkg::WINDOW-1:0]  in_use;
   asw_pkg::up_link_type        up_link   [0:asw_pkg::WINDOW];
   asw_pkg::down_link_type      down_link [0:asw_pkg::WINDOW];

   assign up_link[0]                = asw_pkg::UP_LINK_START;
   assign down_link[asw_pkg::WINDOW] = asw_pkg::DOWN_LINK_END;

   for (genvar i = 0; i < asw_pkg::WINDOW; i++) begin : g_cell
      assign in_use[i] = (i == 0) || (32'(i) < 32'(window_in_use));

      asw_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .in_use   (in_use[i]),
         .up_in    (up_link[i]),
         .up_out   (up_link[i+1]),
         .down_in  (down_link[i+1]),
         .down_out (down_link[i])
      );
   end

   assign head = down_link[0].slot.flags;
   assign tail = up_link[asw_pkg::WINDOW];

endmodule

[hw/rtl/arq_sender_window.sv]
// Sender window of a sliding-window ARQ, Go-Back-N or selective repeat.
// Top level: control sequencer, settings and result register around asw_row.
// Depends on asw_pkg, asw_row and asw_cell.
//
// Usage:
//   req channel carries one item: mode in req_tuser (enqueue packet, enqueue
//   end marker, ack, poll), packet number and poll time in req_tdata.
//   rsp channel returns exactly one result item per request item.
//   csr port sets go_back_n, timeout_us and window_in_use; write only while
//   no item is in flight.
// Sequence from the accepting edge to rsp_tvalid:
//   enqueue ENQ, DONE; poll EVAL, SELECT, UPDATE, DONE (EVAL then DONE when
//   the head is the end marker); ack MATCH, SHIFT while the head is acked, DONE.
//   The window slides one slot per cycle through the cell row. One item is
//   processed at a time; a new item is taken while a finished result still
//   waits on rsp.
// Reset (synchronous, active high) empties the window, zeroes the retransmit
// count and restores the settings to 0, 1000000 and 8.
// When rsp_tready is low the result holds; the next item may still be taken
// and is worked up to its result, which then waits for the output register.
module arq_sender_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pkt_id[15:0], now[47:16]
   input  logic [asw_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode[1:0]
   input  logic [asw_pkg::MODE_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted[0], send_valid[1], send_packet[17:2], send_is_retransmit[18],
   // timed_out[19], end_reached[20], retransmit_total[36:21],
   // window_fill[40:37], zero[47:41]
   output logic [asw_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_wen,
   input  logic [asw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [asw_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   asw_pkg::state_type              state_ff, state_in;

   logic                            gbn_ff;
   logic [asw_pkg::TIME_W-1:0]      timeout_ff;
   logic [asw_pkg::WIU_W-1:0]       wiu_ff;

   logic                            end_ff;
   logic [asw_pkg::PACKET_W-1:0]    pn_ff;
   logic [asw_pkg::TIME_W-1:0]      now_ff;

   logic                            acc_ff;
   logic                            sv_ff;
   logic [asw_pkg::PACKET_W-1:0]    sp_ff;
   logic                            re_ff;
   logic                            tmo_ff;
   logic [asw_pkg::RETX_W-1:0]      retx_ff;

   logic                            rsp_valid_ff;
   asw_pkg::rsp_data_type           rsp_data_ff, rsp_data_in;

   asw_pkg::req_data_type           req_view;
   asw_pkg::cell_cmd_type           cmd;
   asw_pkg::flags_type              head;
   asw_pkg::up_link_type            tail;
   logic                            req_accept;
   logic                            head_acked;
   logic                            head_end;
   logic                            load_rsp;
   logic [asw_pkg::FILL_W-1:0]      fill;

   assign req_view   = req_tdata;
   assign req_tready = (state_ff == asw_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign head_acked = head.occ & head.acked;
   assign head_end   = head.occ & head.last;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   asw_row u_row (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .window_in_use (wiu_ff),
      .head          (head),
      .tail          (tail)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         asw_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  asw_pkg::MODE_ENQ_PACKET: state_in = asw_pkg::ST_ENQ;
                  asw_pkg::MODE_ENQ_END:    state_in = asw_pkg::ST_ENQ;
                  asw_pkg::MODE_ACK:        state_in = asw_pkg::ST_MATCH;
                  default:                  state_in = asw_pkg::ST_EVAL;
               endcase
            end
         end
         asw_pkg::ST_ENQ:    state_in = asw_pkg::ST_DONE;
         asw_pkg::ST_MATCH:  state_in = asw_pkg::ST_SHIFT;
         asw_pkg::ST_SHIFT: begin
            if (!head_acked) state_in = asw_pkg::ST_DONE;
         end
         asw_pkg::ST_EVAL: begin
            state_in = head_end ? asw_pkg::ST_DONE : asw_pkg::ST_SELECT;
         end
         asw_pkg::ST_SELECT: state_in = asw_pkg::ST_UPDATE;
         asw_pkg::ST_UPDATE: state_in = asw_pkg::ST_DONE;
         asw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = asw_pkg::ST_IDLE;
         end
         default: state_in = asw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op         = asw_pkg::OP_HOLD;
      cmd.end_marker = end_ff;
      cmd.packet     = pn_ff;
      cmd.now        = now_ff;
      cmd.timeout    = timeout_ff;
      cmd.rewind     = gbn_ff & tmo_ff;
      load_rsp       = 1'b0;
      case (state_ff)
         asw_pkg::ST_ENQ:    cmd.op = asw_pkg::OP_ENQ;
         asw_pkg::ST_MATCH:  cmd.op = asw_pkg::OP_MATCH;
         asw_pkg::ST_SHIFT: begin
            if (head_acked) cmd.op = asw_pkg::OP_SHIFT;
         end
         asw_pkg::ST_EVAL:   cmd.op = asw_pkg::OP_EVAL;
         asw_pkg::ST_SELECT: cmd.op = asw_pkg::OP_SELECT;
         asw_pkg::ST_UPDATE: cmd.op = asw_pkg::OP_UPDATE;
         asw_pkg::ST_DONE:   load_rsp = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      if (32'(tail.count) > 32'(asw_pkg::FILL_MAX)) begin
         fill = asw_pkg::FILL_MAX;
      end else begin
         fill = asw_pkg::FILL_W'(tail.count);
      end
      rsp_data_in.pad                = '0;
      rsp_data_in.window_fill        = fill;
      rsp_data_in.retransmit_total   = retx_ff;
      rsp_data_in.end_reached        = head_end;
      rsp_data_in.timed_out          = tmo_ff;
      rsp_data_in.send_is_retransmit = re_ff;
      rsp_data_in.send_packet        = sp_ff;
      rsp_data_in.send_valid         = sv_ff;
      rsp_data_in.accepted           = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asw_pkg::ST_IDLE;
         gbn_ff       <= asw_pkg::GBN_RESET;
         timeout_ff   <= asw_pkg::TIMEOUT_RESET;
         wiu_ff       <= asw_pkg::WIU_RESET;
         retx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            case (csr_index)
               asw_pkg::CSR_GO_BACK_N:     gbn_ff     <= csr_wdata[0];
               asw_pkg::CSR_TIMEOUT_US:    timeout_ff <= csr_wdata[asw_pkg::TIME_W-1:0];
               asw_pkg::CSR_WINDOW_IN_USE: wiu_ff     <= csr_wdata[asw_pkg::WIU_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == asw_pkg::ST_UPDATE && sv_ff && re_ff && retx_ff != asw_pkg::RETX_MAX) begin
            retx_ff <= retx_ff + asw_pkg::RETX_W'(1);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         end_ff <= (req_tuser == asw_pkg::MODE_ENQ_END);
         pn_ff  <= req_view.pkt_id;
         now_ff <= req_view.now;
         acc_ff <= 1'b0;
         sv_ff  <= 1'b0;
         sp_ff  <= '0;
         re_ff  <= 1'b0;
         tmo_ff <= 1'b0;
      end
      if (state_ff == asw_pkg::ST_ENQ) begin
         acc_ff <= tail.found;
      end
      if (state_ff == asw_pkg::ST_MATCH) begin
         acc_ff <= tail.hit;
      end
      if (state_ff == asw_pkg::ST_SELECT) begin
         sv_ff  <= tail.taken;
         sp_ff  <= tail.sel_packet;
         tmo_ff <= tail.sel_timed;
         re_ff  <= tail.sel_timed | tail.sel_resend;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[hw/rtl/asw_checker.sv]
// Port-level checks for arq_sender_window, attached by bind.
// Depends on asw_pkg.
module asw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [asw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   asw_pkg::rsp_data_type          rsp_view;
   logic [asw_pkg::RETX_W-1:0]     prev_total_ff;

   assign rsp_view = rsp_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_total_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         prev_total_ff <= rsp_view.retransmit_total;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result item present right after reset");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |->
         ((rsp_view.send_is_retransmit && prev_total_ff != asw_pkg::RETX_MAX) ?
            (rsp_view.retransmit_total == prev_total_ff + asw_pkg::RETX_W'(1)) :
            (rsp_view.retransmit_total == prev_total_ff)))
      else $error("retransmit total out of step with retransmissions");

   a_timeout_send: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.timed_out |->
         rsp_view.send_valid && rsp_view.send_is_retransmit && !rsp_view.accepted)
      else $error("timeout without a retransmission");

endmodule

bind arq_sender_window asw_checker u_asw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for arq_sender_window: a queue-fed stream driver, a result
// monitor and an untimed model of the sender window that predicts every result item.
// Depends on asw_pkg and the arq_sender_window RTL.
module tb;
   import asw_pkg::*;

   typedef struct packed {
      mode_type            mode;
      logic [PACKET_W-1:0] packet;
      logic [TIME_W-1:0]   stamp;
   } cmd_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [MODE_W-1:0]      req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // window model
   slot_type          win [WINDOW];
   logic              gbn_mode;
   logic [TIME_W-1:0] tmo_limit;
   logic [WIU_W-1:0]  span_cfg;
   logic [RETX_W-1:0] retx_count;

   cmd_type           pending [$];
   rsp_data_type      expected [$];
   logic [PACKET_W-1:0] live [$];
   logic [PACKET_W-1:0] next_pn;
   logic [TIME_W-1:0] cur_now = 32'hFFFF_F000;
   int                errors = 0;
   logic              req_took = 1'b0;
   int                burst_left = 8;
   int                gap_left = 0;
   int                squeeze_count = 0;
   int                squeeze_seen = 0;
   int                hold_left = 0;
   logic [3:0]        tick = '0;
   logic [15:0]       ready_mask = '1;

   arq_sender_window dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_window();
      for (int i = 0; i < WINDOW; i++) win[i] = '0;
      retx_count = '0;
      gbn_mode = GBN_RESET;
      tmo_limit = TIMEOUT_RESET;
      span_cfg = WIU_RESET;
   endfunction

   function automatic int active_slots();
      if (span_cfg == 0) return 1;
      if (span_cfg > WINDOW) return WINDOW;
      return int'(span_cfg);
   endfunction

   // drop the head, pull the occupied run down by one, clear the rest
   function automatic void slide_head(int w);
      int i;
      i = 0;
      while (i + 1 < w && win[i + 1].flags.occ) begin
         win[i] = win[i + 1];
         i++;
      end
      while (i < w) begin
         win[i] = '0;
         i++;
      end
   endfunction

   function automatic rsp_data_type advance_window(mode_type m, logic [PACKET_W-1:0] pn,
                                                   logic [TIME_W-1:0] now);
      rsp_data_type      r;
      int                w;
      int                fill;
      logic              timed;
      logic [TIME_W-1:0] age;
      r = '0;
      w = active_slots();
      fill = 0;
      case (m)
         MODE_ENQ_PACKET, MODE_ENQ_END: begin
            for (int i = 0; i < w; i++) begin
               if (!win[i].flags.occ) begin
                  win[i] = '0;
                  win[i].flags.occ = 1'b1;
                  if (m == MODE_ENQ_PACKET) win[i].packet = pn;
                  else win[i].flags.last = 1'b1;
                  r.accepted = 1'b1;
                  break;
               end
            end
         end
         MODE_ACK: begin
            for (int i = 0; i < w; i++) begin
               if (win[i].flags.occ && !win[i].flags.last && win[i].packet == pn) begin
                  win[i].flags.acked = 1'b1;
                  r.accepted = 1'b1;
               end
            end
            while (win[0].flags.occ && win[0].flags.acked) slide_head(w);
         end
         default: begin
            if (!(win[0].flags.occ && win[0].flags.last)) begin
               for (int i = 0; i < w; i++) begin
                  age = now - win[i].stamp;
                  timed = win[i].flags.occ && !win[i].flags.last && win[i].flags.sent &&
                          !win[i].flags.acked && age > tmo_limit;
                  if (timed) begin
                     r.timed_out = 1'b1;
                     if (gbn_mode) begin
                        for (int k = 0; k < w && win[k].flags.occ && !win[k].flags.last;
                             k++) begin
                           win[k].flags.sent = 1'b0;
                           win[k].flags.acked = 1'b0;
                           win[k].flags.resend = 1'b1;
                        end
                     end
                  end
                  if (win[i].flags.occ && !win[i].flags.last &&
                      (!win[i].flags.sent || timed)) begin
                     win[i].flags.sent = 1'b1;
                     win[i].stamp = now;
                     r.send_valid = 1'b1;
                     r.send_packet = win[i].packet;
                     if (timed || win[i].flags.resend) begin
                        r.send_is_retransmit = 1'b1;
                        win[i].flags.resend = 1'b0;
                        if (retx_count != RETX_MAX) retx_count++;
                     end
                     break;
                  end
               end
            end
         end
      endcase
      for (int i = 0; i < w; i++) if (win[i].flags.occ) fill++;
      if (fill > 15) fill = 15;
      r.end_reached = win[0].flags.occ && win[0].flags.last;
      r.retransmit_total = retx_count;
      r.window_fill = FILL_W'(fill);
      return r;
   endfunction

   task automatic report(string msg);
      errors++;
      if (errors <= 100) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v)
         report($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got_v, want_v));
   endtask

   // monitor: predict on each accepted item, compare each accepted result
   always @(posedge clock) begin
      rsp_data_type got;
      rsp_data_type want;
      req_data_type fields;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            fields = req_data_type'(req_tdata);
            expected.push_back(advance_window(mode_type'(req_tuser), fields.pkt_id,
                                              fields.now));
            pending.delete(0);
            req_took <= 1'b1;
         end else begin
            req_took <= 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_data_type'(rsp_tdata);
            if (expected.size() == 0) begin
               report($sformatf("result 0x%0h with nothing expected", rsp_tdata));
            end else begin
               want = expected.pop_front();
               check_field("accepted", got.accepted, want.accepted);
               check_field("send_valid", got.send_valid, want.send_valid);
               check_field("send_packet", got.send_packet, want.send_packet);
               check_field("send_is_retransmit", got.send_is_retransmit,
                           want.send_is_retransmit);
               check_field("timed_out", got.timed_out, want.timed_out);
               check_field("end_reached", got.end_reached, want.end_reached);
               check_field("retransmit_total", got.retransmit_total, want.retransmit_total);
               check_field("window_fill", got.window_fill, want.window_fill);
               check_field("pad", got.pad, '0);
            end
         end
      end
   end

   // driver: bursts of items with random gaps, hold each item until taken
   always @(negedge clock) begin
      logic    offer;
      cmd_type head;
      if (req_took) begin
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         end
      end
      offer = 1'b0;
      if (gap_left > 0) begin
         gap_left--;
      end else if (pending.size() > 0) begin
         head = pending[0];
         offer = 1'b1;
         req_tdata <= req_data_type'{now: head.stamp, pkt_id: head.packet};
         req_tuser <= head.mode;
      end
      req_tvalid <= offer;
   end

   // receiver: random 16-bit stall pattern, long hold-off on request
   always @(negedge clock) begin
      if (squeeze_seen != squeeze_count) begin
         squeeze_seen = squeeze_count;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (tick == 0) begin
            case ($urandom_range(0, 3))
               0: ready_mask = '1;
               3: ready_mask = 16'($urandom) & 16'($urandom);
               default: ready_mask = 16'($urandom);
            endcase
         end
         rsp_tready <= ready_mask[tick];
         tick = tick + 1'b1;
      end
   end

   task automatic queue_item(mode_type m, logic [PACKET_W-1:0] pn, logic [TIME_W-1:0] t);
      pending.push_back(cmd_type'{mode: m, packet: pn, stamp: t});
   endtask

   task automatic offer_packet(logic [PACKET_W-1:0] pn);
      queue_item(MODE_ENQ_PACKET, pn, $urandom);
      live.push_back(pn);
      if (live.size() > 32) live.delete(0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_GO_BACK_N:  gbn_mode = value[0];
         CSR_TIMEOUT_US: tmo_limit = value;
         default:        span_cfg = value[WIU_W-1:0];
      endcase
   endtask

   task automatic settle();
      while (pending.size() != 0 || expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic gen_phase(int count, bit with_end, int unsigned step_max);
      int unsigned  r;
      int unsigned  s;
      int           idx;
      mode_type     m;
      logic [PACKET_W-1:0] pn;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            m = mode_type'($urandom_range(0, 3));
            if (m == MODE_ENQ_END && !with_end) m = MODE_POLL;
            queue_item(m, 16'($urandom), $urandom);
         end else if (r < 35) begin
            if ($urandom_range(0, 19) == 0 && live.size() > 0) begin
               pn = live[live.size() - 1];
            end else begin
               pn = next_pn;
               next_pn++;
            end
            offer_packet(pn);
         end else if (with_end && r < 38) begin
            queue_item(MODE_ENQ_END, 16'($urandom), $urandom);
         end else if (r < 68) begin
            s = $urandom_range(0, 99);
            if (live.size() == 0 || s >= 85) begin
               queue_item(MODE_ACK, 16'($urandom), $urandom);
            end else begin
               idx = (s < 60) ? 0 : $urandom_range(0, (live.size() > 8) ? 7 : live.size() - 1);
               queue_item(MODE_ACK, live[idx], $urandom);
               live.delete(idx);
            end
         end else begin
            cur_now = cur_now + $urandom_range(0, step_max);
            queue_item(MODE_POLL, 16'($urandom), cur_now);
         end
      end
   endtask

   initial begin
      logic [TIME_W-1:0] tmo;
      int unsigned       step;
      clear_window();
      next_pn = 16'($urandom);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty window, full window, duplicates, unsent ack, timeouts in selective repeat
      queue_item(MODE_POLL, 16'h0000, 32'h0000_0000);
      queue_item(MODE_ACK, 16'h0000, 32'hFFFF_FFFF);
      offer_packet(16'hFFFF);
      offer_packet(16'h0000);
      offer_packet(16'h1234);
      offer_packet(16'h8001);
      offer_packet(16'h0005);
      offer_packet(16'h0006);
      offer_packet(16'h0007);
      offer_packet(16'hFFFF);
      offer_packet(16'h0009);
      queue_item(MODE_ENQ_END, 16'hFFFF, 32'h0000_0000);
      queue_item(MODE_ACK, 16'h0006, 32'h0000_0000);
      queue_item(MODE_POLL, 16'h0000, 32'hFFFF_FFFF);
      queue_item(MODE_POLL, 16'h0000, 32'd10);
      queue_item(MODE_ACK, 16'hFFFF, 32'h0000_0000);
      queue_item(MODE_POLL, 16'h0000, 32'd3_000_000);
      queue_item(MODE_POLL, 16'h0000, 32'hFFFF_FF00);
      settle();

      // go-back-n rewind
      write_reg(CSR_GO_BACK_N, 32'd1);
      queue_item(MODE_POLL, 16'h0000, 32'h4000_0000);
      queue_item(MODE_POLL, 16'h0000, 32'h4000_0001);
      queue_item(MODE_ACK, 16'h1234, 32'h0000_0000);
      settle();

      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0:       tmo = $urandom_range(20, 300);
            1:       tmo = 32'd1;
            2:       tmo = 32'hFFFF_FFFF;
            default: tmo = $urandom_range(300, 3000);
         endcase
         step = (p % 4 == 1) ? 2 : (p % 4 == 2) ? 3000 : tmo / 2;
         write_reg(CSR_GO_BACK_N, 32'(p % 2));
         write_reg(CSR_TIMEOUT_US, tmo);
         write_reg(CSR_WINDOW_IN_USE, 32'((p * 5 + 8) % 16));
         gen_phase(150, 1'b0, step);
         if (p % 4 == 0) begin
            @(posedge clock);
            squeeze_count++;
         end
         settle();
      end

      // end marker: rewind stops at it, ack cannot pass it, poll is blocked
      write_reg(CSR_GO_BACK_N, 32'd1);
      write_reg(CSR_TIMEOUT_US, 32'd50);
      write_reg(CSR_WINDOW_IN_USE, 32'd8);
      while (live.size() > 0) queue_item(MODE_ACK, live.pop_front(), $urandom);
      offer_packet(16'hA000);
      queue_item(MODE_ENQ_END, 16'h0000, $urandom);
      offer_packet(16'hA001);
      queue_item(MODE_POLL, 16'h0000, cur_now);
      queue_item(MODE_POLL, 16'h0000, cur_now + 200);
      queue_item(MODE_ACK, 16'hA000, $urandom);
      queue_item(MODE_POLL, 16'h0000, cur_now + 400);
      queue_item(MODE_ACK, 16'h0000, $urandom);
      cur_now = cur_now + 400;
      gen_phase(100, 1'b1, 30);
      settle();

      if (errors == 0) begin
         $display("** arq_sender_window: PASSED **");
      end else begin
         $display("** arq_sender_window: FAILED **");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("** arq_sender_window: FAILED **");
      $finish;
   end

endmodule

[files.f]
hw/rtl/asw_pkg.sv
hw/rtl/asw_cell.sv
hw/rtl/asw_row.sv
hw/rtl/arq_sender_window.sv
hw/rtl/asw_checker.sv
bench/tb.sv
